FILE: hdl/ncs_pkg.sv
// ----------------------------------------------------------------------------
// Nested comment stripper package
// Shared types, character codes, scan modes and result kinds.
// ----------------------------------------------------------------------------
package ncs_pkg;

  // Default nesting limit for block comments.
  localparam int DEF_MAX_DEPTH = 255;

  // Depth of the record queue between the scanner and the output stage.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Characters that steer the scanner.
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_NL    = 8'h0A;

  // Scan modes.
  localparam int MODE_W = 3;
  localparam logic [MODE_W-1:0] M_NORMAL = 3'd0;
  localparam logic [MODE_W-1:0] M_SLASH  = 3'd1;
  localparam logic [MODE_W-1:0] M_LINE   = 3'd2;
  localparam logic [MODE_W-1:0] M_BLOCK  = 3'd3;
  localparam logic [MODE_W-1:0] M_BSLASH = 3'd4;
  localparam logic [MODE_W-1:0] M_BSTAR  = 3'd5;

  // Result kinds.
  localparam logic [1:0] K_CHAR     = 2'd0;
  localparam logic [1:0] K_END      = 2'd1;
  localparam logic [1:0] K_OPEN_END = 2'd2;
  localparam logic [1:0] K_OVERFLOW = 2'd3;

  // One result item.
  typedef struct packed {
    logic [7:0] ch;
    logic [1:0] kind;
  } res_t;

  // All results caused by one request: one or two items.
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } rec_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

FILE: hdl/ncs_front.sv
// ----------------------------------------------------------------------------
// Nested comment stripper scanner
// Holds mode and nesting depth, classifies each request and builds the
// record of results it causes.
// ----------------------------------------------------------------------------
module ncs_front import ncs_pkg::*; #(
  parameter int MAX_DEPTH = DEF_MAX_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  logic [7:0] in_char,
  input  logic       in_is_end,
  input  qstat_t     qstat,
  output logic       in_full,
  output logic       rec_push,
  output rec_t       rec
);

  localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_DEPTH);
  localparam logic [DEPTH_W-1:0] DEPTH_ONE = DEPTH_W'(1);

  logic [MODE_W-1:0]  mode_r, mode_nxt, mode;
  logic [DEPTH_W-1:0] depth_r, depth_nxt, depth_dec;
  logic               accept;
  logic               has_res;
  logic               at_limit;

  // A request is taken whenever the queue has room.
  assign in_full = qstat.full;
  assign accept  = in_push && !qstat.full;

  // Unused mode codes behave as normal text.
  assign mode      = (mode_r > M_BSTAR) ? M_NORMAL : mode_r;
  assign at_limit  = (depth_r >= DEPTH_MAX);
  assign depth_dec = (depth_r != '0) ? (depth_r - DEPTH_ONE) : depth_r;

  // Next state and the results caused by this request.
  always_comb begin
    mode_nxt  = mode;
    depth_nxt = depth_r;
    has_res   = 1'b0;
    rec       = '0;
    if (in_is_end) begin
      has_res   = 1'b1;
      mode_nxt  = M_NORMAL;
      depth_nxt = '0;
      if (mode == M_SLASH) begin
        rec.two     = 1'b1;
        rec.r0.ch   = CH_SLASH;
        rec.r0.kind = K_CHAR;
        rec.r1.kind = K_END;
      end else if (mode == M_BLOCK || mode == M_BSLASH || mode == M_BSTAR) begin
        rec.r0.kind = K_OPEN_END;
      end else begin
        rec.r0.kind = K_END;
      end
    end else begin
      case (mode)
        M_SLASH: begin
          if (in_char == CH_STAR) begin
            // Outermost open: depth restarts at one.
            mode_nxt  = M_BLOCK;
            depth_nxt = DEPTH_ONE;
          end else if (in_char == CH_SLASH) begin
            mode_nxt = M_LINE;
          end else begin
            has_res     = 1'b1;
            rec.two     = 1'b1;
            rec.r0.ch   = CH_SLASH;
            rec.r0.kind = K_CHAR;
            rec.r1.ch   = in_char;
            rec.r1.kind = K_CHAR;
            mode_nxt    = M_NORMAL;
          end
        end
        M_LINE: begin
          if (in_char == CH_NL) begin
            mode_nxt = M_NORMAL;
          end
        end
        M_BSLASH: begin
          if (in_char == CH_STAR) begin
            // Nested open; saturates at the limit and flags it.
            mode_nxt = M_BLOCK;
            if (at_limit) begin
              depth_nxt   = DEPTH_MAX;
              has_res     = 1'b1;
              rec.r0.kind = K_OVERFLOW;
            end else begin
              depth_nxt = depth_r + DEPTH_ONE;
            end
          end else if (in_char != CH_SLASH) begin
            mode_nxt = M_BLOCK;
          end
        end
        M_BSTAR: begin
          if (in_char == CH_SLASH) begin
            depth_nxt = depth_dec;
            mode_nxt  = (depth_dec == '0) ? M_NORMAL : M_BLOCK;
          end else if (in_char != CH_STAR) begin
            mode_nxt = M_BLOCK;
          end
        end
        M_BLOCK: begin
          if (in_char == CH_SLASH) begin
            mode_nxt = M_BSLASH;
          end else if (in_char == CH_STAR) begin
            mode_nxt = M_BSTAR;
          end
        end
        default: begin
          if (in_char == CH_SLASH) begin
            mode_nxt = M_SLASH;
          end else begin
            has_res     = 1'b1;
            rec.r0.ch   = in_char;
            rec.r0.kind = K_CHAR;
            mode_nxt    = M_NORMAL;
          end
        end
      endcase
    end
  end

  assign rec_push = accept && has_res;

  // Scanner state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_NORMAL;
      depth_r <= '0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      depth_r <= depth_nxt;
    end
  end

endmodule

FILE: hdl/ncs_queue.sv
// ----------------------------------------------------------------------------
// Nested comment stripper record queue
// Short first-in first-out buffer that decouples scanner and output stage.
// ----------------------------------------------------------------------------
module ncs_queue import ncs_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   wr_en,
  input  rec_t   wr_rec,
  input  logic   rd_en,
  output rec_t   rd_rec,
  output qstat_t qstat
);

  rec_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_r, rptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_wr, do_rd;

  assign qstat.full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign qstat.empty = (cnt_r == '0);
  assign do_wr       = wr_en && !qstat.full;
  assign do_rd       = rd_en && !qstat.empty;
  assign rd_rec      = slot_r[rptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wptr_r] <= wr_rec;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_wr) begin
        wptr_r <= wptr_r + QPTR_W'(1);
      end
      if (do_rd) begin
        rptr_r <= rptr_r + QPTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

endmodule

FILE: hdl/ncs_back.sv
// ----------------------------------------------------------------------------
// Nested comment stripper output stage
// Takes records from the queue and hands out their results one at a time.
// ----------------------------------------------------------------------------
module ncs_back import ncs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  qstat_t     qstat,
  input  rec_t       rd_rec,
  output logic       rd_en,
  input  logic       out_pop,
  output logic       out_empty,
  output logic [7:0] out_char,
  output logic [1:0] out_kind,
  output logic       out_last
);

  rec_t cur_r;
  logic vld_r;
  logic idx_r;
  logic taken;
  logic cur_done;
  logic load;
  res_t res;

  assign taken    = out_pop && vld_r;
  assign cur_done = !cur_r.two || idx_r;
  // Refill when empty or when the final result of the record leaves.
  assign load     = !vld_r || (taken && cur_done);
  assign rd_en    = load && !qstat.empty;

  // Result selection.
  assign res       = idx_r ? cur_r.r1 : cur_r.r0;
  assign out_empty = !vld_r;
  assign out_char  = res.ch;
  assign out_kind  = res.kind;
  assign out_last  = cur_done;

  // Current record payload.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      cur_r <= rd_rec;
    end
  end

  // Output control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= 1'b0;
    end else if (load) begin
      vld_r <= !qstat.empty;
      idx_r <= 1'b0;
    end else if (taken) begin
      idx_r <= 1'b1;
    end
  end

endmodule

FILE: hdl/nested_comment_stripper.sv
// ----------------------------------------------------------------------------
// Nested comment stripper
// Removes nested block comments and line comments from a byte stream.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake          Payload
//  in       input      in_push / in_full  in_char, in_is_end
//  out      output     out_empty/out_pop  out_char, out_kind, out_last
//
//  One request is taken per cycle while the record queue has room; the
//  scanner's mode and depth registers change only on a taken request. A result
//  passes the record queue and the output register before the output ports;
//  a request with two results holds the output for two pops.
//  Synchronous active-low reset returns the scanner to normal text, depth 0,
//  and empties the queue and the output stage.
//  When out_pop stays low, up to four records wait in the queue plus one at
//  the output before in_full rises.
// ----------------------------------------------------------------------------
module nested_comment_stripper import ncs_pkg::*; #(
  parameter int MAX_DEPTH = DEF_MAX_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_char,
  input  logic       in_is_end,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_char,
  output logic [1:0] out_kind,
  output logic       out_last
);

  qstat_t qstat;
  rec_t   wr_rec, rd_rec;
  logic   wr_en, rd_en;

  // Scanner.
  ncs_front #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_char   (in_char),
    .in_is_end (in_is_end),
    .qstat     (qstat),
    .in_full   (in_full),
    .rec_push  (wr_en),
    .rec       (wr_rec)
  );

  // Record queue.
  ncs_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (wr_en),
    .wr_rec (wr_rec),
    .rd_en  (rd_en),
    .rd_rec (rd_rec),
    .qstat  (qstat)
  );

  // Output stage.
  ncs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .qstat     (qstat),
    .rd_rec    (rd_rec),
    .rd_en     (rd_en),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_char  (out_char),
    .out_kind  (out_kind),
    .out_last  (out_last)
  );

endmodule

FILE: hdl/ncs_checker.sv
// ----------------------------------------------------------------------------
// Nested comment stripper port checker
// Watches the top-level ports for result ordering and coding rules.
// ----------------------------------------------------------------------------
module ncs_checker import ncs_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_empty,
  input logic       out_pop,
  input logic [7:0] out_char,
  input logic [1:0] out_kind,
  input logic       out_last
);

  // Reset leaves no result waiting.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("result shown right after reset");

  // A waiting result that is not popped stays in place.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=>
      (!out_empty && $stable(out_char) && $stable(out_kind) && $stable(out_last)))
    else $error("result changed while stalled");

  // Only kept characters carry a character code.
  a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_kind != K_CHAR) |-> (out_char == 8'd0))
    else $error("non-character result with nonzero character");

  // End marks and overflow flags always close their request's results.
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_kind != K_CHAR) |-> out_last)
    else $error("status result not marked last");

  // The second of a pair follows a popped result that was not last.
  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_pop && !out_last) |=> !out_empty)
    else $error("second result of a pair missing");

endmodule

bind nested_comment_stripper ncs_checker u_ncs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_char  (out_char),
  .out_kind  (out_kind),
  .out_last  (out_last)
);
